// File: design/sbus_pkg.sv
// shared constants, codes and types of the frame decoder
package sbus_pkg;

    localparam int FRAME_BYTES   = 25;
    localparam int CHANNELS      = 16;
    localparam int CHAN_BITS     = 11;
    localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
    localparam int CHAN_BYTES    = PAYLOAD_BYTES - 1;
    localparam int FLAG_POS      = CHAN_BYTES;
    localparam int POS_W         = 5;
    localparam int CHIDX_W       = $clog2(CHANNELS);
    localparam int JOB_DEPTH     = 2;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 8'd3;

    localparam logic [7:0]  HEADER_RST  = 8'd15;
    localparam logic [7:0]  FOOTER_RST  = 8'd0;
    localparam logic [10:0] NEUTRAL_RST = 11'd992;
    localparam logic [15:0] GAIN_RST    = 16'd7993;

    // flag byte bits
    localparam int FLAG_D1   = 0;
    localparam int FLAG_D2   = 1;
    localparam int FLAG_LOST = 2;
    localparam int FLAG_FS   = 3;

    typedef struct packed {
        logic [7:0] header_value;
        logic [7:0] footer_value;
    } sbus_sync_cfg_t;

    typedef struct packed {
        logic [10:0] neutral_offset;
        logic [15:0] gain_q16;
    } sbus_scale_cfg_t;

    typedef struct packed {
        logic [CHAN_BYTES-1:0][7:0] chan_bytes;
        logic [3:0]                 flags;
        logic [31:0]                count;
    } sbus_job_t;

endpackage

// File: design/sbus_intf.sv
// channel interfaces: received bytes, decoded results, register writes
interface sbus_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sbus_result_if;
    logic              valid;
    logic              ready;
    logic [3:0]        channel_index;
    logic signed [7:0] channel_value;
    logic              channel_valid;
    logic              digital_one;
    logic              digital_two;
    logic              frame_lost;
    logic              failsafe;
    logic [31:0]       frame_count;
    logic              last;

    modport source (output valid, output channel_index, output channel_value,
                    output channel_valid, output digital_one, output digital_two,
                    output frame_lost, output failsafe, output frame_count,
                    output last, input ready);
    modport sink (input valid, input channel_index, input channel_value,
                  input channel_valid, input digital_one, input digital_two,
                  input frame_lost, input failsafe, input frame_count,
                  input last, output ready);
endinterface

interface sbus_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/sbus_frame_decoder_top.sv
// top level of the serial frame decoder: config registers, front, job queue, back
// Accepts one received byte per cycle on rx and delivers decoded results on res.
// The front end tracks sync (hunt for header, collect 23 bytes, check footer) and
// takes a byte every cycle; on a good footer it pushes the captured frame into a
// two-frame job queue. The back end unpacks one 11-bit channel per cycle unless res stalls,
// scales it through a single 11x16 multiplier and saturates it into the output register,
// so a good frame gives 16 results, or one flags-only result when the
// frame-lost flag is set. rx stalls only on the footer byte while the job queue is
// full. No clearing pass after reset. Registers are written on cfg whenever its
// valid is high (ready stays high); indexes 0..3 are header, footer, neutral offset
// and gain, other indexes are ignored.
module sbus_frame_decoder_top
    import sbus_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sbus_byte_if.sink     rx,
    sbus_result_if.source res,
    sbus_cfg_if.sink      cfg
);

    logic [7:0]      header_reg;
    logic [7:0]      footer_reg;
    logic [10:0]     neutral_reg;
    logic [15:0]     gain_reg;

    sbus_sync_cfg_t  sync_cfg;
    sbus_scale_cfg_t scale_cfg;
    sbus_job_t       push_job, head_job;
    logic            job_push, job_full, job_pop, job_avail;

    // config port never stalls
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= HEADER_RST;
            footer_reg  <= FOOTER_RST;
            neutral_reg <= NEUTRAL_RST;
            gain_reg    <= GAIN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_HEADER:  header_reg  <= cfg.data[7:0];
                CFG_FOOTER:  footer_reg  <= cfg.data[7:0];
                CFG_NEUTRAL: neutral_reg <= cfg.data[10:0];
                CFG_GAIN:    gain_reg    <= cfg.data;
                default:     ;
            endcase
        end
    end

    assign sync_cfg.header_value    = header_reg;
    assign sync_cfg.footer_value    = footer_reg;
    assign scale_cfg.neutral_offset = neutral_reg;
    assign scale_cfg.gain_q16       = gain_reg;

    // sync and capture
    sbus_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .sync_cfg (sync_cfg),
        .job_full (job_full),
        .job_push (job_push),
        .job      (push_job)
    );

    // decouples byte intake from result drain
    sbus_job_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .full     (job_full),
        .pop      (job_pop),
        .avail    (job_avail),
        .head     (head_job)
    );

    // unpack, scale, output register
    sbus_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .scale_cfg (scale_cfg),
        .job_avail (job_avail),
        .job       (head_job),
        .job_pop   (job_pop),
        .res       (res)
    );

endmodule

// File: design/sbus_front.sv
// byte-level sync and frame capture, pushes good frames to the job queue
module sbus_front
    import sbus_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    sbus_byte_if.sink      rx,
    input  sbus_sync_cfg_t sync_cfg,
    input  logic           job_full,
    output logic           job_push,
    output sbus_job_t      job
);

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_COLLECT = 2'd1;
    localparam logic [1:0] PH_FOOTER  = 2'd2;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAYLOAD_BYTES);

    logic [1:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       last_footer_reg, last_footer_next;
    logic [31:0]      frames_reg, frames_next;
    logic [7:0]       store_reg [PAYLOAD_BYTES];
    logic             accept;
    logic [POS_W-1:0] wr_idx;

    assign rx.ready = !((phase_reg == PH_FOOTER) && job_full);
    assign accept   = rx.valid && rx.ready;
    assign wr_idx   = pos_reg - POS_W'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        last_footer_next = last_footer_reg;
        frames_next      = frames_reg;
        job_push         = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if ((rx.rx_byte == sync_cfg.header_value) &&
                        (last_footer_reg == sync_cfg.footer_value))
                    begin
                        phase_next = PH_COLLECT;
                        pos_next   = POS_W'(1);
                    end
                    else
                    begin
                        pos_next = '0;
                    end
                end
                PH_COLLECT:
                begin
                    pos_next = pos_reg + POS_W'(1);
                    if (pos_reg == POS_LAST)
                        phase_next = PH_FOOTER;
                end
                PH_FOOTER:
                begin
                    phase_next = PH_HUNT;
                    pos_next   = '0;
                    if (rx.rx_byte == sync_cfg.footer_value)
                    begin
                        last_footer_next = rx.rx_byte;
                        frames_next      = frames_reg + 32'd1;
                        job_push         = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    pos_next   = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < CHAN_BYTES; i++)
            job.chan_bytes[i] = store_reg[i];
        job.flags = store_reg[FLAG_POS][3:0];
        job.count = frames_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            pos_reg         <= '0;
            last_footer_reg <= '0;
            frames_reg      <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            last_footer_reg <= last_footer_next;
            frames_reg      <= frames_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == PH_COLLECT))
            store_reg[wr_idx] <= rx.rx_byte;
    end

    // collect phase always points at a payload slot
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_COLLECT) |-> ((pos_reg != '0) && (pos_reg <= POS_LAST)))
        else $error("byte position out of range while collecting");

endmodule

// File: design/sbus_job_fifo.sv
// short queue of captured frames between front and back
module sbus_job_fifo
    import sbus_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  sbus_job_t push_job,
    output logic      full,
    input  logic      pop,
    output logic      avail,
    output sbus_job_t head
);

    localparam int PTR_W = $clog2(JOB_DEPTH);
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);

    sbus_job_t        mem_reg [JOB_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(JOB_DEPTH));
    assign avail   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && avail;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("frame pushed into a full queue");

endmodule

// File: design/sbus_back.sv
// channel unpack, scale and saturate, one result per cycle into the output register unless res stalls
module sbus_back
    import sbus_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  sbus_scale_cfg_t scale_cfg,
    input  logic            job_avail,
    input  sbus_job_t       job,
    output logic            job_pop,
    sbus_result_if.source   res
);

    logic [CHIDX_W-1:0] k_reg, k_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHIDX_W-1:0] idx_reg;
    logic [7:0]         value_reg;
    logic               chv_reg, d1_reg, d2_reg, lost_reg, fs_reg, last_reg;
    logic [31:0]        count_reg;

    logic               load, lost, is_last;
    logic [7:0]         base;
    logic [CHAN_BYTES*8-1:0] chan_flat;
    logic [CHAN_BITS-1:0] raw, mag, q;
    logic signed [CHAN_BITS:0] diff;
    logic [CHAN_BITS+15:0] prod;
    logic [7:0]         sat;

    assign lost    = job.flags[FLAG_LOST];
    assign is_last = lost || (k_reg == CHIDX_W'(CHANNELS - 1));
    assign load    = job_avail && (!out_valid_reg || res.ready);
    assign job_pop = load && is_last;

    // bit offset 11*k into the channel bytes
    always_comb
    begin
        chan_flat = job.chan_bytes;
        base = {1'b0, k_reg, 3'b000} + {3'b000, k_reg, 1'b0} + {4'b0000, k_reg};
        raw  = chan_flat[base +: CHAN_BITS];
        diff = $signed({1'b0, raw}) - $signed({1'b0, scale_cfg.neutral_offset});
        mag  = diff[CHAN_BITS] ? CHAN_BITS'(-diff) : diff[CHAN_BITS-1:0];
        prod = mag * scale_cfg.gain_q16;
        q    = prod[CHAN_BITS+15:16];
        if (diff[CHAN_BITS])
            sat = (q >= CHAN_BITS'(128)) ? 8'h80 : 8'(~q[7:0] + 8'd1);
        else
            sat = (q > CHAN_BITS'(127)) ? 8'h7f : q[7:0];
    end

    always_comb
    begin
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            k_next         = is_last ? '0 : k_reg + CHIDX_W'(1);
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idx_reg   <= lost ? '0 : k_reg;
            value_reg <= lost ? 8'h00 : sat;
            chv_reg   <= !lost;
            d1_reg    <= lost ? 1'b0 : job.flags[FLAG_D1];
            d2_reg    <= lost ? 1'b0 : job.flags[FLAG_D2];
            lost_reg  <= lost;
            fs_reg    <= job.flags[FLAG_FS];
            count_reg <= job.count;
            last_reg  <= is_last;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.channel_index = idx_reg;
    assign res.channel_value = $signed(value_reg);
    assign res.channel_valid = chv_reg;
    assign res.digital_one   = d1_reg;
    assign res.digital_two   = d2_reg;
    assign res.frame_lost    = lost_reg;
    assign res.failsafe      = fs_reg;
    assign res.frame_count   = count_reg;
    assign res.last          = last_reg;

    // a frame part way through unpacking stays at the queue head
    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg != '0) |-> job_avail)
        else $error("channel counter running without a frame");

    a_flags_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.channel_valid) |-> (res.last && res.frame_lost))
        else $error("flags-only result not marked last");

endmodule
